// File: rtl/stable_min_priority_queue_assert.svh
// ---------------------------------------------------------------------------
// stable_min_priority_queue_assert.svh
// Assertion macros used by the priority queue checker.
// ---------------------------------------------------------------------------
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SMPQ_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SMPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

`endif

// File: rtl/smpq_pkg.sv
// ---------------------------------------------------------------------------
// smpq_pkg
// Types and codes shared by the sorted priority queue and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned OCC_W   = 5;

    // operation codes on the kind port
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                       push;
        logic                       pop;
        logic signed [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]          prio;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/smpq_cell.sv
// ---------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted queue: holds an entry, compares it against the
// pushed priority, and shifts toward the tail on insert or the head on pop.
// ---------------------------------------------------------------------------
`default_nettype none

module smpq_cell (
    input  wire logic                                   clk,
    input  wire smpq_pkg::cell_cmd_t                    cmd,
    input  wire logic                                   occupied,
    input  wire logic                                   left_after,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0]    left_value,
    input  wire logic [smpq_pkg::PRIO_W-1:0]            left_prio,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0]    right_value,
    input  wire logic [smpq_pkg::PRIO_W-1:0]            right_prio,
    output logic                                        after,
    output logic signed [smpq_pkg::VALUE_W-1:0]         value,
    output logic [smpq_pkg::PRIO_W-1:0]                 prio
);
    import smpq_pkg::*;

    logic signed [VALUE_W-1:0]  value_reg;
    logic signed [VALUE_W-1:0]  value_next;
    logic [PRIO_W-1:0]          prio_reg;
    logic [PRIO_W-1:0]          prio_next;

    // new entry goes behind this one (ties keep arrival order)
    assign after = occupied && (prio_reg <= cmd.prio);

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.push)
        begin
            if (!after)
            begin
                if (left_after)
                begin
                    value_next = cmd.value;
                    prio_next  = cmd.prio;
                end
                else
                begin
                    value_next = left_value;
                    prio_next  = left_prio;
                end
            end
        end
        else if (cmd.pop)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

// File: rtl/stable_min_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded sorted priority queue built as a shift-register row of cells.
// ---------------------------------------------------------------------------
// Usage: every word presented with start high is taken at that clock edge;
// busy never rises, so a push or pop can be issued in every cycle. The
// result word shows on the result ports in the cycle after the command,
// with done high for exactly that cycle; the receiver cannot stall it and
// must capture it then. The rate is one word per cycle, set by the single
// compare-and-shift step that all cells do in parallel. A push lands
// behind every entry of lower or equal priority (lower numbers leave
// first, equal priorities leave in arrival order); a push into a full
// queue is dropped with status full, a pop from an empty queue reports
// status empty. occupancy is the entry count after the word, cut to 5 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module stable_min_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   kind,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0]    item_value,
    input  wire logic [smpq_pkg::PRIO_W-1:0]            item_priority,
    output logic                                        done,
    output logic [1:0]                                  status,
    output logic                                        popped_valid,
    output logic signed [smpq_pkg::VALUE_W-1:0]         popped_value,
    output logic [smpq_pkg::PRIO_W-1:0]                 popped_priority,
    output logic [smpq_pkg::OCC_W-1:0]                  occupancy
);
    import smpq_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // entry count; cells at or beyond it hold stale data
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    // result word registers
    logic                       done_reg;
    status_t                    status_reg;
    status_t                    status_next;
    logic                       pvalid_reg;
    logic                       pvalid_next;
    logic signed [VALUE_W-1:0]  pvalue_reg;
    logic signed [VALUE_W-1:0]  pvalue_next;
    logic [PRIO_W-1:0]          pprio_reg;
    logic [PRIO_W-1:0]          pprio_next;
    logic [OCC_W-1:0]           occ_reg;

    logic                       accept;
    logic                       full;
    logic                       empty;
    cell_cmd_t                  cmd;

    // per-cell taps along the row
    logic                       cell_after [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0]  cell_value [QUEUE_DEPTH];
    logic [PRIO_W-1:0]          cell_prio  [QUEUE_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);

    // command broadcast: refused operations leave every cell as is
    always_comb
    begin
        cmd.push  = accept && (kind == KIND_PUSH) && !full;
        cmd.pop   = accept && (kind == KIND_POP) && !empty;
        cmd.value = item_value;
        cmd.prio  = item_priority;
    end

    // the cell row: each cell sees its neighbors on both sides
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                       left_after;
        logic signed [VALUE_W-1:0]  left_value;
        logic [PRIO_W-1:0]          left_prio;
        logic signed [VALUE_W-1:0]  right_value;
        logic [PRIO_W-1:0]          right_prio;

        if (i == 0)
        begin : g_head
            // the head always takes the new entry unless it stays put
            assign left_after = 1'b1;
            assign left_value = cell_value[i];
            assign left_prio  = cell_prio[i];
        end
        else
        begin : g_body
            assign left_after = cell_after[i-1];
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (CNT_W'(i) < count_reg),
            .left_after  (left_after),
            .left_value  (left_value),
            .left_prio   (left_prio),
            .right_value (right_value),
            .right_prio  (right_prio),
            .after       (cell_after[i]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_DONE;
        pvalid_next = 1'b0;
        pvalue_next = '0;
        pprio_next  = '0;
        if (kind == KIND_PUSH)
        begin
            if (full)
                status_next = STATUS_FULL;
            else
                count_next = count_reg + 1'b1;
        end
        else
        begin
            if (empty)
                status_next = STATUS_EMPTY;
            else
            begin
                count_next  = count_reg - 1'b1;
                pvalid_next = 1'b1;
                pvalue_next = cell_value[0];
                pprio_next  = cell_prio[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            pvalid_reg <= pvalid_next;
            pvalue_reg <= pvalue_next;
            pprio_reg  <= pprio_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign popped_valid    = pvalid_reg;
    assign popped_value    = pvalue_reg;
    assign popped_priority = pprio_reg;
    assign occupancy       = occ_reg;

endmodule

`default_nettype wire

// File: rtl/smpq_checker.sv
// ---------------------------------------------------------------------------
// smpq_checker
// Port-level checks on the priority queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stable_min_priority_queue_assert.svh"

module smpq_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic                                   busy,
    input  wire logic                                   kind,
    input  wire logic                                   done,
    input  wire logic [1:0]                             status,
    input  wire logic                                   popped_valid,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0]    popped_value,
    input  wire logic [smpq_pkg::PRIO_W-1:0]            popped_priority,
    input  wire logic [smpq_pkg::OCC_W-1:0]             occupancy
);
    import smpq_pkg::*;

    // one result word per accepted command, in the next cycle
    `SMPQ_ASSERT_NEXT(a_done_follows, start && !busy, done)
    `SMPQ_ASSERT_NEXT(a_no_stray_done, !(start && !busy), !done)
    // an empty-queue pop leaves nothing behind and returns nothing
    `SMPQ_ASSERT_IMPLY(a_empty_pop, done && (status == STATUS_EMPTY),
        (occupancy == '0) && !popped_valid && (popped_value == '0))
    // a removed entry only comes from a successful pop
    `SMPQ_ASSERT_IMPLY(a_pop_source, done && popped_valid,
        (status == STATUS_DONE) && ($past(kind) == KIND_POP))
    // pushes never report a removed entry
    `SMPQ_ASSERT_IMPLY(a_push_quiet, done && ($past(kind) == KIND_PUSH),
        !popped_valid && (popped_priority == '0) && (status != STATUS_EMPTY))

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (.*);

`default_nettype wire
